// ===== rtl/c8ex_pkg.sv =====
// Package: opcodes, flag positions, register state types and word widths.
`default_nettype none

package c8ex_pkg;

    // Stream word widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    // Operation codes
    localparam logic [5:0] OP_NOP   = 6'd0;
    localparam logic [5:0] OP_LDA   = 6'd1;
    localparam logic [5:0] OP_LDX   = 6'd2;
    localparam logic [5:0] OP_LDY   = 6'd3;
    localparam logic [5:0] OP_AND   = 6'd4;
    localparam logic [5:0] OP_ADC   = 6'd5;
    localparam logic [5:0] OP_SBC   = 6'd6;
    localparam logic [5:0] OP_ASL_A = 6'd7;
    localparam logic [5:0] OP_ASL_M = 6'd8;
    localparam logic [5:0] OP_LSR_A = 6'd9;
    localparam logic [5:0] OP_LSR_M = 6'd10;
    localparam logic [5:0] OP_ROL_A = 6'd11;
    localparam logic [5:0] OP_ROL_M = 6'd12;
    localparam logic [5:0] OP_ROR_A = 6'd13;
    localparam logic [5:0] OP_ROR_M = 6'd14;
    localparam logic [5:0] OP_BIT   = 6'd15;
    localparam logic [5:0] OP_TAX   = 6'd16;
    localparam logic [5:0] OP_TAY   = 6'd17;
    localparam logic [5:0] OP_TXA   = 6'd18;
    localparam logic [5:0] OP_TYA   = 6'd19;
    localparam logic [5:0] OP_TSX   = 6'd20;
    localparam logic [5:0] OP_TXS   = 6'd21;
    localparam logic [5:0] OP_CLC   = 6'd22;
    localparam logic [5:0] OP_CLV   = 6'd23;
    localparam logic [5:0] OP_CLD   = 6'd24;
    localparam logic [5:0] OP_CLI   = 6'd25;
    localparam logic [5:0] OP_SEC   = 6'd26;
    localparam logic [5:0] OP_SED   = 6'd27;
    localparam logic [5:0] OP_SEI   = 6'd28;
    localparam logic [5:0] OP_STA   = 6'd29;
    localparam logic [5:0] OP_STX   = 6'd30;
    localparam logic [5:0] OP_STY   = 6'd31;
    localparam logic [5:0] OP_PLP   = 6'd32;
    localparam logic [5:0] OP_PHP   = 6'd33;

    // Status flag bit positions
    localparam int FLAG_C   = 0;
    localparam int FLAG_Z   = 1;
    localparam int FLAG_I   = 2;
    localparam int FLAG_D   = 3;
    localparam int FLAG_B   = 4;
    localparam int FLAG_ONE = 5;
    localparam int FLAG_V   = 6;
    localparam int FLAG_N   = 7;

    localparam logic [7:0] STATUS_RESET = 8'h24;
    localparam logic [7:0] SP_RESET     = 8'hFF;
    localparam logic [7:0] PULL_MASK    = 8'hCF;
    localparam logic [7:0] PUSH_SET     = 8'h30;

    // Shift kinds
    typedef enum logic [1:0] {
        SH_ASL = 2'd0,
        SH_LSR = 2'd1,
        SH_ROL = 2'd2,
        SH_ROR = 2'd3
    } shift_kind_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] status;
    } arch_state_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       write_back;
    } mem_result_t;

endpackage : c8ex_pkg

`default_nettype wire

// ===== rtl/c8ex_exec.sv =====
// Execute logic: ALU, shifter, flags and register updates for one operation.
`default_nettype none

module c8ex_exec
    import c8ex_pkg::*;
(
    input  wire logic [5:0]  opcode,
    input  wire logic [7:0]  operand,
    input  wire arch_state_t cur_state,
    output arch_state_t      nxt_state,
    output mem_result_t      mem_out
);

    logic [7:0]  add_in;
    logic [8:0]  sum;
    logic [7:0]  sh_src;
    logic [7:0]  sh_res;
    logic        sh_cout;
    shift_kind_t sh_kind;
    logic        cin;

    // Update N and Z from a value
    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r         = p;
        r[FLAG_Z] = (v == 8'h00);
        r[FLAG_N] = v[7];
        return r;
    endfunction

    assign cin    = cur_state.status[FLAG_C];
    assign add_in = (opcode == OP_SBC) ? ~operand : operand;
    assign sum    = {1'b0, cur_state.acc} + {1'b0, add_in} + {8'h00, cin};

    // Shift kind from the opcode pair; odd codes work on A, even on the operand
    always_comb
    begin
        sh_kind = shift_kind_t'(2'((opcode - OP_ASL_A) >> 1));
        sh_src  = opcode[0] ? cur_state.acc : operand;
        unique case (sh_kind)
            SH_ASL:
            begin
                sh_res  = {sh_src[6:0], 1'b0};
                sh_cout = sh_src[7];
            end
            SH_LSR:
            begin
                sh_res  = {1'b0, sh_src[7:1]};
                sh_cout = sh_src[0];
            end
            SH_ROL:
            begin
                sh_res  = {sh_src[6:0], cin};
                sh_cout = sh_src[7];
            end
            SH_ROR:
            begin
                sh_res  = {cin, sh_src[7:1]};
                sh_cout = sh_src[0];
            end
            default:
            begin
                sh_res  = sh_src;
                sh_cout = cin;
            end
        endcase
    end

    always_comb
    begin
        nxt_state           = cur_state;
        mem_out.result_byte = 8'h00;
        mem_out.write_back  = 1'b0;
        unique case (opcode)
            OP_LDA:
            begin
                nxt_state.acc    = operand;
                nxt_state.status = set_nz(cur_state.status, operand);
            end
            OP_LDX:
            begin
                nxt_state.x      = operand;
                nxt_state.status = set_nz(cur_state.status, operand);
            end
            OP_LDY:
            begin
                nxt_state.y      = operand;
                nxt_state.status = set_nz(cur_state.status, operand);
            end
            OP_AND:
            begin
                nxt_state.acc    = cur_state.acc & operand;
                nxt_state.status = set_nz(cur_state.status, cur_state.acc & operand);
            end
            OP_ADC, OP_SBC:
            begin
                nxt_state.acc            = sum[7:0];
                nxt_state.status         = set_nz(cur_state.status, sum[7:0]);
                nxt_state.status[FLAG_C] = sum[8];
                nxt_state.status[FLAG_V] = ~(cur_state.acc[7] ^ add_in[7])
                                           & (cur_state.acc[7] ^ sum[7]);
            end
            OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A:
            begin
                nxt_state.acc            = sh_res;
                nxt_state.status         = set_nz(cur_state.status, sh_res);
                nxt_state.status[FLAG_C] = sh_cout;
            end
            OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M:
            begin
                nxt_state.status         = set_nz(cur_state.status, sh_res);
                nxt_state.status[FLAG_C] = sh_cout;
                mem_out.result_byte      = sh_res;
                mem_out.write_back       = 1'b1;
            end
            OP_BIT:
            begin
                nxt_state.status[FLAG_N] = operand[7];
                nxt_state.status[FLAG_V] = operand[6];
                nxt_state.status[FLAG_Z] = ((operand & cur_state.acc) == 8'h00);
            end
            OP_TAX:
            begin
                nxt_state.x      = cur_state.acc;
                nxt_state.status = set_nz(cur_state.status, cur_state.acc);
            end
            OP_TAY:
            begin
                nxt_state.y      = cur_state.acc;
                nxt_state.status = set_nz(cur_state.status, cur_state.acc);
            end
            OP_TXA:
            begin
                nxt_state.acc    = cur_state.x;
                nxt_state.status = set_nz(cur_state.status, cur_state.x);
            end
            OP_TYA:
            begin
                nxt_state.acc    = cur_state.y;
                nxt_state.status = set_nz(cur_state.status, cur_state.y);
            end
            OP_TSX:
            begin
                nxt_state.x      = cur_state.sp;
                nxt_state.status = set_nz(cur_state.status, cur_state.sp);
            end
            OP_TXS:   nxt_state.sp = cur_state.x;
            OP_CLC:   nxt_state.status[FLAG_C] = 1'b0;
            OP_CLV:   nxt_state.status[FLAG_V] = 1'b0;
            OP_CLD:   nxt_state.status[FLAG_D] = 1'b0;
            OP_CLI:   nxt_state.status[FLAG_I] = 1'b0;
            OP_SEC:   nxt_state.status[FLAG_C] = 1'b1;
            OP_SED:   nxt_state.status[FLAG_D] = 1'b1;
            OP_SEI:   nxt_state.status[FLAG_I] = 1'b1;
            OP_STA:
            begin
                mem_out.result_byte = cur_state.acc;
                mem_out.write_back  = 1'b1;
            end
            OP_STX:
            begin
                mem_out.result_byte = cur_state.x;
                mem_out.write_back  = 1'b1;
            end
            OP_STY:
            begin
                mem_out.result_byte = cur_state.y;
                mem_out.write_back  = 1'b1;
            end
            OP_PLP:
            begin
                nxt_state.status         = operand & PULL_MASK;
                nxt_state.status[FLAG_ONE] = 1'b1;
                nxt_state.sp             = cur_state.sp + 8'd1;
            end
            OP_PHP:
            begin
                mem_out.result_byte = cur_state.status | PUSH_SET;
                mem_out.write_back  = 1'b1;
                nxt_state.sp        = cur_state.sp - 8'd1;
            end
            default:
            begin
                // NOP and unused codes: hold everything
                nxt_state = cur_state;
            end
        endcase
    end

endmodule : c8ex_exec

`default_nettype wire

// ===== rtl/cpu8_register_alu_flags_execute_unit.sv =====
// Top level: input register, execute logic, architectural registers, result register.
//
//  Channel | Dir | Handshake                    | Word contents
//  --------+-----+------------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | opcode[5:0], operand[13:6], zero pad
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | result_byte, write_back, A, X, Y, status
//
//  An accepted word moves through the input register into the result register on m_axis;
//  one word is taken every cycle unless m_axis stalls. The execute step (combinational ALU
//  between the input register and the result register) updates A, X, Y, SP and status as
//  the word moves forward, so each operation sees the registers left by the one before.
//  Reset clears both valid flags and loads A=X=Y=0, SP=0xFF, status=0x24.
//  A stall on m_axis holds the result register and the input register; the input side
//  still accepts while the input register is empty.
`default_nettype none

module cpu8_register_alu_flags_execute_unit
    import c8ex_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // opcode[5:0], operand[13:6], zeros[15:14]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // result_byte[7:0], write_back[8], acc_value[16:9], x_value[24:17],
    // y_value[32:25], status_value[40:33], zeros[47:41]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready
);

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [5:0]  in_op_reg;
    logic [7:0]  in_operand_reg;

    // Architectural registers
    arch_state_t state_reg, state_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    mem_result_t out_mem_reg;
    arch_state_t out_state_reg;

    arch_state_t exec_state;
    mem_result_t exec_mem;

    logic advance;
    logic exec_fire;
    logic in_fire;

    // Advance when the result register is free or being drained this cycle
    assign advance       = !out_valid_reg || m_axis_tready;
    assign exec_fire     = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    c8ex_exec u_exec
    (
        .opcode    (in_op_reg),
        .operand   (in_operand_reg),
        .cur_state (state_reg),
        .nxt_state (exec_state),
        .mem_out   (exec_mem)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (exec_fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        state_next = exec_fire ? exec_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.acc    <= 8'h00;
            state_reg.x      <= 8'h00;
            state_reg.y      <= 8'h00;
            state_reg.sp     <= SP_RESET;
            state_reg.status <= STATUS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: load on handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg      <= s_axis_tdata[5:0];
            in_operand_reg <= s_axis_tdata[13:6];
        end
        if (exec_fire)
        begin
            out_mem_reg   <= exec_mem;
            out_state_reg <= exec_state;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_state_reg.status,
                            out_state_reg.y,
                            out_state_reg.x,
                            out_state_reg.acc,
                            out_mem_reg.write_back,
                            out_mem_reg.result_byte};

    // Bit 5 of status is always set
    a_status_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.status[FLAG_ONE])
        else $error("status bit 5 cleared");

    // No write-back means a zero result byte
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_mem_reg.write_back) |-> (out_mem_reg.result_byte == 8'h00))
        else $error("result byte non-zero without write-back");

    // Registers change only when an operation executes
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(state_reg))
        else $error("registers changed without an operation");

    // Stack pointer moves only on push, pull or transfer from X
    a_sp_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && in_op_reg != OP_PHP && in_op_reg != OP_PLP && in_op_reg != OP_TXS)
        |=> $stable(state_reg.sp))
        else $error("stack pointer moved on an unrelated operation");

endmodule : cpu8_register_alu_flags_execute_unit

`default_nettype wire
